### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the CAN frame text parser.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cftp_pkg.sv
// Package for the CAN frame text parser: field widths, default limits and
// the upper-case hex digit decoder. No dependencies.
package cftp_pkg;

   localparam int CHAR_W      = 8;
   localparam int ID_W        = 12;
   localparam int PAYLOAD_W   = 64;
   localparam int NIBBLE_W    = 4;
   localparam int RSP_DATA_W  = ((ID_W + PAYLOAD_W + 7) / 8) * 8;

   localparam int DEF_MAX_ID_DIGITS      = 3;
   localparam int DEF_MAX_PAYLOAD_DIGITS = 16;

   localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;

   typedef struct packed {
      logic                is_hex;
      logic [NIBBLE_W-1:0] value;
   } nibble_type;

   function automatic nibble_type hex_decode(input logic [CHAR_W-1:0] ch);
      nibble_type res;
      res.is_hex = 1'b0;
      res.value  = '0;
      case (ch) inside
         [8'h30:8'h39]: begin
            res.is_hex = 1'b1;
            res.value  = NIBBLE_W'(ch - 8'h30);
         end
         [8'h41:8'h46]: begin
            res.is_hex = 1'b1;
            res.value  = NIBBLE_W'(ch - 8'h37);
         end
         default: begin
            res.is_hex = 1'b0;
         end
      endcase
      return res;
   endfunction

endpackage

### rtl/can_frame_text_parser.sv
// CAN frame text parser: turns ID#PAYLOAD text into identifier and payload.
// Depends on cftp_pkg and assert_macros.svh.
//
// Usage:
//   req_ channel carries one ASCII character per transaction in req_tdata,
//   with req_tlast high on the final character of a frame.
//   rsp_ channel carries one result per frame: rsp_tdata holds the 12-bit
//   identifier (bits 11:0) and the 64-bit payload (bits 75:12); rsp_tuser
//   holds the frame valid flag. Identifier and payload are zero when the
//   frame is malformed.
//   Every character is parsed in the cycle it is accepted, so one character
//   per cycle is sustained while no result waits on a low rsp_tready. The
//   result appears on rsp_ in the cycle after the final character is accepted.
//   The single result register is the only buffer: while a result waits
//   and rsp_tready is low, req_tready drops; it stays high while the
//   result is being taken in the same cycle.
//   Reset clears the parser state to the start of a frame and empties the
//   result register. Parser state also returns to the start after every
//   final character.
module can_frame_text_parser #(
   parameter int MAX_ID_DIGITS      = cftp_pkg::DEF_MAX_ID_DIGITS,
   parameter int MAX_PAYLOAD_DIGITS = cftp_pkg::DEF_MAX_PAYLOAD_DIGITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cftp_pkg::CHAR_W-1:0]     req_tdata,   // [7:0] char_in
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cftp_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [11:0] frame_id, [75:12] frame_payload
   output logic [0:0]                      rsp_tuser    // [0] frame_valid
);

`include "assert_macros.svh"

   localparam int IdCntW  = $clog2(MAX_ID_DIGITS + 1);
   localparam int PayCntW = $clog2(MAX_PAYLOAD_DIGITS + 1);
   localparam int IdW     = cftp_pkg::ID_W;
   localparam int PayW    = cftp_pkg::PAYLOAD_W;
   localparam int NibW    = cftp_pkg::NIBBLE_W;

   localparam logic [1:0] PH_ID      = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_ERROR   = 2'd2;

   logic [1:0]         phase_ff, phase_in, phase_upd;
   logic [IdCntW-1:0]  id_digits_ff, id_digits_in, id_digits_upd;
   logic [IdW-1:0]     id_accum_ff, id_accum_in, id_accum_upd;
   logic [PayCntW-1:0] pay_digits_ff, pay_digits_in, pay_digits_upd;
   logic [PayW-1:0]    pay_accum_ff, pay_accum_in, pay_accum_upd;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IdW-1:0]     rsp_id_ff, rsp_id_in;
   logic [PayW-1:0]    rsp_pay_ff, rsp_pay_in;
   logic               rsp_ok_ff, rsp_ok_in;

   logic                 req_accept;
   logic                 frame_ok;
   cftp_pkg::nibble_type nib;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign nib        = cftp_pkg::hex_decode(req_tdata);

   always_comb begin
      phase_upd      = phase_ff;
      id_digits_upd  = id_digits_ff;
      id_accum_upd   = id_accum_ff;
      pay_digits_upd = pay_digits_ff;
      pay_accum_upd  = pay_accum_ff;
      case (phase_ff)
         PH_ID: begin
            if (nib.is_hex && (id_digits_ff < IdCntW'(MAX_ID_DIGITS))) begin
               id_accum_upd  = {id_accum_ff[IdW-NibW-1:0], nib.value};
               id_digits_upd = id_digits_ff + IdCntW'(1);
            end else if ((req_tdata == cftp_pkg::CHAR_HASH) && (id_digits_ff != '0)) begin
               phase_upd = PH_PAYLOAD;
            end else begin
               phase_upd = PH_ERROR;
            end
         end
         PH_PAYLOAD: begin
            if (nib.is_hex && (pay_digits_ff < PayCntW'(MAX_PAYLOAD_DIGITS))) begin
               pay_accum_upd  = {pay_accum_ff[PayW-NibW-1:0], nib.value};
               pay_digits_upd = pay_digits_ff + PayCntW'(1);
            end else begin
               phase_upd = PH_ERROR;
            end
         end
         default: begin
            phase_upd = PH_ERROR;
         end
      endcase

      frame_ok = (phase_upd == PH_PAYLOAD) && (pay_digits_upd >= PayCntW'(2)) &&
                 !pay_digits_upd[0];

      phase_in      = phase_ff;
      id_digits_in  = id_digits_ff;
      id_accum_in   = id_accum_ff;
      pay_digits_in = pay_digits_ff;
      pay_accum_in  = pay_accum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_ok_in     = rsp_ok_ff;

      if (req_accept) begin
         if (req_tlast) begin
            phase_in      = PH_ID;
            id_digits_in  = '0;
            id_accum_in   = '0;
            pay_digits_in = '0;
            pay_accum_in  = '0;
            rsp_valid_in  = 1'b1;
            rsp_id_in     = frame_ok ? id_accum_upd : '0;
            rsp_pay_in    = frame_ok ? pay_accum_upd : '0;
            rsp_ok_in     = frame_ok;
         end else begin
            phase_in      = phase_upd;
            id_digits_in  = id_digits_upd;
            id_accum_in   = id_accum_upd;
            pay_digits_in = pay_digits_upd;
            pay_accum_in  = pay_accum_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ID;
         id_digits_ff  <= '0;
         id_accum_ff   <= '0;
         pay_digits_ff <= '0;
         pay_accum_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         id_digits_ff  <= id_digits_in;
         id_accum_ff   <= id_accum_in;
         pay_digits_ff <= pay_digits_in;
         pay_accum_ff  <= pay_accum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff  <= rsp_id_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cftp_pkg::RSP_DATA_W - IdW - PayW){1'b0}}, rsp_pay_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_ok_ff;

   `ASSERT_SAME(a_invalid_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, (rsp_id_ff == '0) && (rsp_pay_ff == '0), "invalid frame carries nonzero data")
   `ASSERT_NEXT(a_last_gives_rsp, clock, reset, req_accept && req_tlast, rsp_valid_ff, "final character gave no transaction")
   `ASSERT_NEXT(a_last_clears, clock, reset, req_accept && req_tlast, (phase_ff == PH_ID) && (id_digits_ff == '0) && (pay_digits_ff == '0), "state not cleared after frame")
   `ASSERT_ALWAYS(a_digit_limits, clock, reset, (id_digits_ff <= IdCntW'(MAX_ID_DIGITS)) && (pay_digits_ff <= PayCntW'(MAX_PAYLOAD_DIGITS)), "digit count beyond limit")

endmodule
